>>> src/ordered_list_engine_unit_macros.svh
// ============================================================================
// Ordered list engine assertion macros
// Shared concurrent assertion forms used by the ordered list engine RTL.
// ============================================================================
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OLST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list engine: assertion failed");
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list engine: assertion failed");
`else
`define OLST_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/olst_pkg.sv
// ============================================================================
// Ordered list engine package
// Shared constants, command codes, state type and control structures.
// ============================================================================
package olst_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [4:0] F_INS_FIRST   = 5'd0;
    localparam logic [4:0] F_INS_BEF_POS = 5'd1;
    localparam logic [4:0] F_INS_AT_POS  = 5'd2;
    localparam logic [4:0] F_INS_AFT_POS = 5'd3;
    localparam logic [4:0] F_INS_BEF_KEY = 5'd4;
    localparam logic [4:0] F_INS_AFT_KEY = 5'd5;
    localparam logic [4:0] F_INS_LAST    = 5'd6;
    localparam logic [4:0] F_DEL_FIRST   = 5'd7;
    localparam logic [4:0] F_DEL_BEF_POS = 5'd8;
    localparam logic [4:0] F_DEL_AT_POS  = 5'd9;
    localparam logic [4:0] F_DEL_AFT_POS = 5'd10;
    localparam logic [4:0] F_DEL_BEF_KEY = 5'd11;
    localparam logic [4:0] F_DEL_AT_KEY  = 5'd12;
    localparam logic [4:0] F_DEL_AFT_KEY = 5'd13;
    localparam logic [4:0] F_DEL_LAST    = 5'd14;
    localparam logic [4:0] F_SEARCH      = 5'd15;
    localparam logic [4:0] F_DUMP        = 5'd16;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_BADPOS = 3'd3;
    localparam logic [2:0] ST_NOKEY  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_KEYWALK,
        S_SETUP,
        S_SEEK,
        S_INS_A,
        S_INS_B,
        S_DEL_WR,
        S_DUMP,
        S_RESP
    } state_t;

    // Outcome of decoding a request
    typedef enum logic [2:0] {
        DK_NONE,
        DK_RESP,
        DK_POS,
        DK_KEY,
        DK_DUMP
    } dec_t;

    // Read address source for the stores
    typedef enum logic [1:0] {
        RS_HOLD,
        RS_FIRST,
        RS_LINK
    } rsel_t;

    typedef struct packed {
        logic  load_cmd;
        logic  dec_save;
        logic  key_save;
        logic  pred_save;
        logic  k_clr;
        logic  k_inc;
        rsel_t rsel;
        logic  ins_a;
        logic  ins_b;
        logic  del_wr;
        logic  out_resp;
        logic  out_dump;
    } olst_cmd_t;

    typedef struct packed {
        dec_t dec;
        logic is_ins;
        logic idx_zero;
        logic seek_hit;
        logic key_hit;
        logic keyres_resp;
        logic walk_end;
        logic out_free;
    } olst_status_t;

endpackage

>>> src/olst_ram.sv
// ============================================================================
// Ordered list engine RAM
// Generic single write port, single read port memory with registered read.
// ============================================================================
module olst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/olst_ctrl.sv
// ============================================================================
// Ordered list engine controller
// Sequences decode, list walks, link updates and result delivery.
// ============================================================================
module olst_ctrl
    import olst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  olst_status_t st,
    output olst_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsel   = RS_HOLD;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.dec_save = 1'b1;
                case (st.dec)
                    DK_NONE: state_next = S_IDLE;
                    DK_RESP: state_next = S_RESP;
                    DK_POS:  state_next = S_SETUP;
                    DK_KEY:
                    begin
                        cmd.rsel   = RS_FIRST;
                        cmd.k_clr  = 1'b1;
                        state_next = S_KEYWALK;
                    end
                    DK_DUMP:
                    begin
                        cmd.rsel   = RS_FIRST;
                        cmd.k_clr  = 1'b1;
                        state_next = S_DUMP;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_KEYWALK:
            begin
                if (st.key_hit || st.walk_end)
                begin
                    cmd.key_save = 1'b1;
                    state_next   = (st.key_hit && !st.keyres_resp) ? S_SETUP : S_RESP;
                end
                else
                begin
                    cmd.rsel  = RS_LINK;
                    cmd.k_inc = 1'b1;
                end
            end
            S_SETUP:
            begin
                if (st.idx_zero)
                begin
                    if (st.is_ins)
                    begin
                        state_next = S_INS_A;
                    end
                    else
                    begin
                        cmd.rsel   = RS_FIRST;
                        state_next = S_DEL_WR;
                    end
                end
                else
                begin
                    cmd.rsel   = RS_FIRST;
                    cmd.k_clr  = 1'b1;
                    state_next = S_SEEK;
                end
            end
            S_SEEK:
            begin
                if (st.seek_hit)
                begin
                    cmd.pred_save = 1'b1;
                    if (st.is_ins)
                    begin
                        state_next = S_INS_A;
                    end
                    else
                    begin
                        cmd.rsel   = RS_LINK;
                        state_next = S_DEL_WR;
                    end
                end
                else
                begin
                    cmd.rsel  = RS_LINK;
                    cmd.k_inc = 1'b1;
                end
            end
            S_INS_A:
            begin
                cmd.ins_a  = 1'b1;
                state_next = st.idx_zero ? S_RESP : S_INS_B;
            end
            S_INS_B:
            begin
                cmd.ins_b  = 1'b1;
                state_next = S_RESP;
            end
            S_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
                state_next = S_RESP;
            end
            S_DUMP:
            begin
                if (st.out_free)
                begin
                    cmd.out_dump = 1'b1;
                    if (st.walk_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rsel  = RS_LINK;
                        cmd.k_inc = 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.out_resp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> src/olst_dp.sv
// ============================================================================
// Ordered list engine datapath
// Request registers, element and link stores, walk counter and result register.
// ============================================================================
`include "ordered_list_engine_unit_macros.svh"

module olst_dp
    import olst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [79:0]  s_tdata,
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  olst_cmd_t    cmd,
    output olst_status_t st
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Request
    logic [4:0]  func_reg;
    logic [31:0] value_reg;
    logic [15:0] pos_reg;
    logic [31:0] key_reg;

    // List state
    logic [SW-1:0]       first_reg;
    logic [CAPACITY-1:0] free_reg;
    logic [CW-1:0]       count_reg;

    // Walk and edit
    logic [CW-1:0] k_reg;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] cur_slot_reg;
    logic [SW-1:0] pred_reg;
    logic [SW-1:0] succ_reg;
    logic [SW-1:0] ns_reg;
    logic [2:0]    status_reg;
    logic [6:0]    found_reg;
    logic [31:0]   fval_reg;

    // Result register
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [6:0]  out_pos_reg;
    logic [31:0] out_val_reg;
    logic        out_last_reg;
    logic [6:0]  out_count_reg;

    logic [DATA_WIDTH-1:0] value_word;
    logic [DATA_WIDTH-1:0] key_word;
    logic [DATA_WIDTH-1:0] target_word;
    logic [DATA_WIDTH-1:0] elem_rdata;
    logic [SW-1:0]         link_rdata;
    logic [SW-1:0]         raddr;
    logic [SW-1:0]         ns;
    logic                  elem_we;
    logic                  link_we;
    logic [SW-1:0]         link_waddr;
    logic [SW-1:0]         link_wdata;
    logic                  hit;
    logic [CW-1:0]         k_plus;
    logic [16:0]           p_ext;
    logic [16:0]           n_ext;
    dec_t                  d_kind;
    logic [2:0]            d_status;
    logic [CW-1:0]         d_idx;

    assign value_word  = DATA_WIDTH'($signed(value_reg));
    assign key_word    = DATA_WIDTH'($signed(key_reg));
    assign target_word = (func_reg == F_SEARCH) ? value_word : key_word;
    assign hit         = (elem_rdata == target_word);
    assign k_plus      = CW'(k_reg + 1'b1);
    assign p_ext       = {1'b0, pos_reg};
    assign n_ext       = 17'(count_reg);

    // Request decode against the count before the request
    always_comb
    begin
        d_kind   = DK_RESP;
        d_status = ST_OK;
        d_idx    = '0;
        if (func_reg > F_DUMP)
        begin
            d_kind = DK_NONE;
        end
        else if (func_reg == F_DUMP || func_reg == F_SEARCH)
        begin
            if (count_reg == '0)
            begin
                d_status = ST_EMPTY;
            end
            else
            begin
                d_kind = (func_reg == F_DUMP) ? DK_DUMP : DK_KEY;
            end
        end
        else if (func_reg <= F_INS_LAST)
        begin
            if (n_ext >= 17'(CAPACITY))
            begin
                d_status = ST_FULL;
            end
            else
            begin
                case (func_reg)
                    F_INS_FIRST:
                    begin
                        d_kind = DK_POS;
                    end
                    F_INS_BEF_POS:
                    begin
                        if (p_ext >= 17'd2 && p_ext <= n_ext + 17'd2)
                        begin
                            d_kind = DK_POS;
                            d_idx  = CW'(p_ext - 17'd2);
                        end
                        else
                        begin
                            d_status = ST_BADPOS;
                        end
                    end
                    F_INS_AT_POS:
                    begin
                        if (p_ext >= 17'd1 && p_ext <= n_ext + 17'd1)
                        begin
                            d_kind = DK_POS;
                            d_idx  = CW'(p_ext - 17'd1);
                        end
                        else
                        begin
                            d_status = ST_BADPOS;
                        end
                    end
                    F_INS_AFT_POS:
                    begin
                        if (p_ext >= 17'd1 && p_ext <= n_ext)
                        begin
                            d_kind = DK_POS;
                            d_idx  = CW'(p_ext);
                        end
                        else
                        begin
                            d_status = ST_BADPOS;
                        end
                    end
                    F_INS_BEF_KEY, F_INS_AFT_KEY:
                    begin
                        if (count_reg == '0)
                        begin
                            d_status = ST_EMPTY;
                        end
                        else
                        begin
                            d_kind = DK_KEY;
                        end
                    end
                    default:
                    begin
                        d_kind = DK_POS;
                        d_idx  = count_reg;
                    end
                endcase
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                d_status = ST_EMPTY;
            end
            else
            begin
                case (func_reg)
                    F_DEL_FIRST:
                    begin
                        d_kind = DK_POS;
                    end
                    F_DEL_BEF_POS:
                    begin
                        if (p_ext >= 17'd2 && p_ext <= n_ext + 17'd1)
                        begin
                            d_kind = DK_POS;
                            d_idx  = CW'(p_ext - 17'd2);
                        end
                        else
                        begin
                            d_status = ST_BADPOS;
                        end
                    end
                    F_DEL_AT_POS:
                    begin
                        if (p_ext >= 17'd1 && p_ext <= n_ext)
                        begin
                            d_kind = DK_POS;
                            d_idx  = CW'(p_ext - 17'd1);
                        end
                        else
                        begin
                            d_status = ST_BADPOS;
                        end
                    end
                    F_DEL_AFT_POS:
                    begin
                        if (p_ext >= 17'd1 && p_ext < n_ext)
                        begin
                            d_kind = DK_POS;
                            d_idx  = CW'(p_ext);
                        end
                        else
                        begin
                            d_status = ST_BADPOS;
                        end
                    end
                    F_DEL_BEF_KEY, F_DEL_AT_KEY, F_DEL_AFT_KEY:
                    begin
                        d_kind = DK_KEY;
                    end
                    default:
                    begin
                        d_kind = DK_POS;
                        d_idx  = CW'(count_reg - 1'b1);
                    end
                endcase
            end
        end
    end

    // Lowest free slot
    always_comb
    begin
        ns = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                ns = SW'(i);
            end
        end
    end

    always_comb
    begin
        case (cmd.rsel)
            RS_FIRST: raddr = first_reg;
            RS_LINK:  raddr = link_rdata;
            default:  raddr = cur_slot_reg;
        endcase
    end

    assign elem_we    = cmd.ins_a;
    assign link_we    = cmd.ins_a || cmd.ins_b || (cmd.del_wr && idx_reg != '0);
    assign link_waddr = cmd.ins_a ? ns : pred_reg;
    always_comb
    begin
        if (cmd.ins_a)
        begin
            link_wdata = (idx_reg == '0) ? first_reg : succ_reg;
        end
        else if (cmd.ins_b)
        begin
            link_wdata = ns_reg;
        end
        else
        begin
            link_wdata = link_rdata;
        end
    end

    olst_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (ns),
        .wdata (value_word),
        .raddr (raddr),
        .rdata (elem_rdata)
    );

    olst_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            free_reg      <= '1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_a)
            begin
                free_reg[ns] <= 1'b0;
                count_reg    <= CW'(count_reg + 1'b1);
                if (idx_reg == '0)
                begin
                    first_reg <= ns;
                end
            end
            if (cmd.del_wr)
            begin
                free_reg[cur_slot_reg] <= 1'b1;
                count_reg              <= CW'(count_reg - 1'b1);
                if (idx_reg == '0)
                begin
                    first_reg <= link_rdata;
                end
            end
            if (cmd.out_resp || cmd.out_dump)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_slot_reg <= raddr;
        if (cmd.load_cmd)
        begin
            func_reg  <= s_tuser;
            value_reg <= s_tdata[31:0];
            pos_reg   <= s_tdata[47:32];
            key_reg   <= s_tdata[79:48];
        end
        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_plus;
        end
        if (cmd.dec_save)
        begin
            status_reg <= d_status;
            idx_reg    <= d_idx;
            found_reg  <= '0;
            fval_reg   <= '0;
        end
        if (cmd.key_save)
        begin
            if (!hit)
            begin
                status_reg <= ST_NOKEY;
            end
            else if (func_reg == F_SEARCH)
            begin
                found_reg <= 7'(k_plus);
                fval_reg  <= 32'($signed(value_word));
            end
            else if (st.keyres_resp)
            begin
                status_reg <= ST_BADPOS;
            end
            else if (func_reg == F_INS_BEF_KEY || func_reg == F_DEL_AT_KEY)
            begin
                idx_reg <= k_reg;
            end
            else if (func_reg == F_INS_AFT_KEY || func_reg == F_DEL_AFT_KEY)
            begin
                idx_reg <= k_plus;
            end
            else
            begin
                idx_reg <= CW'(k_reg - 1'b1);
            end
        end
        if (cmd.pred_save)
        begin
            pred_reg <= cur_slot_reg;
            succ_reg <= link_rdata;
        end
        if (cmd.ins_a)
        begin
            ns_reg <= ns;
        end
        if (cmd.out_resp)
        begin
            out_status_reg <= status_reg;
            out_pos_reg    <= found_reg;
            out_val_reg    <= fval_reg;
            out_last_reg   <= 1'b1;
            out_count_reg  <= 7'(count_reg);
        end
        else if (cmd.out_dump)
        begin
            out_status_reg <= ST_OK;
            out_pos_reg    <= 7'(k_plus);
            out_val_reg    <= 32'($signed(elem_rdata));
            out_last_reg   <= st.walk_end;
            out_count_reg  <= 7'(count_reg);
        end
    end

    assign st.dec         = d_kind;
    assign st.is_ins      = (func_reg <= F_INS_LAST);
    assign st.idx_zero    = (idx_reg == '0);
    assign st.seek_hit    = (k_plus == idx_reg);
    assign st.key_hit     = hit;
    assign st.keyres_resp = (func_reg == F_SEARCH)
                          || (func_reg == F_DEL_BEF_KEY && k_reg == '0)
                          || (func_reg == F_DEL_AFT_KEY && k_plus >= count_reg);
    assign st.walk_end    = (k_plus == count_reg);
    assign st.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_val_reg, out_pos_reg};

    `OLST_ASSERT_IMPLY(a_free_matches_count, clk, rst_n, 1'b1,
        $countones(free_reg) + int'(count_reg) == CAPACITY)
    `OLST_ASSERT_IMPLY(a_insert_has_room, clk, rst_n, cmd.ins_a, free_reg != '0)
    `OLST_ASSERT_IMPLY(a_load_when_free, clk, rst_n, cmd.out_resp || cmd.out_dump,
        !out_valid_reg || m_tready)

endmodule

>>> src/ordered_list_engine_unit.sv
// ============================================================================
// Ordered list engine
// Fixed capacity singly linked list of signed words driven by list requests.
// ============================================================================
// Usage: one request enters on the slave stream (s_tuser carries the request
// code, s_tdata the value, position and key). Each request yields one result
// on the master stream, except a dump of a non-empty list, which yields one
// result per element, and an undefined request code, which yields none.
// m_tlast marks the final result of a request and m_tuser carries its status.
// Timing: a request is taken only while the engine is idle. After decode, a
// position request walks the list one element per cycle to the element before
// its target. A key request first scans for the key, one compare per cycle,
// then walks again to the edit point. A dump emits one element per cycle while
// the receiver keeps up.
// The walk rate is set by the registered read of the link store, whose output
// addresses the next read directly.
// Reset empties the list and marks every slot free; no clearing pass is run.
// When the receiver stalls, the result register holds and a dump walk pauses.
// ============================================================================
module ordered_list_engine_unit
    import olst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // item_value [31:0], list_position [47:32], match_key [79:48]
    input  logic [79:0] s_tdata,
    // func [4:0]
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found_position [6:0], element_value [38:7], element_count [45:39], zero fill
    output logic [47:0] m_tdata,
    // status [2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    olst_cmd_t    cmd;
    olst_status_t st;

    // The controller sequences each request; it sees only status flags.
    olst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the stores, the walk state and the result register.
    olst_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Ordered list engine testbench
// Drives random and directed list requests into the engine, predicts every
// result with a behavioural model of the list and compares each result field by field.
// ============================================================================
module testbench
    import olst_pkg::*;
();

    localparam int CAP       = 32;
    localparam int LIMIT     = 400000;
    localparam int RAND_REQS = 110;

    // One list request as it travels on the slave stream.
    typedef struct packed {
        logic [4:0]  func;
        logic [31:0] value;
        logic [15:0] pos;
        logic [31:0] key;
    } list_req_t;

    // One result as it travels on the master stream.
    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  found_pos;
        logic [31:0] elem;
        logic        last;
        logic [6:0]  count;
    } list_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    ordered_list_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Requests waiting to be driven, and the results the predictor expects.
    list_req_t pending_reqs[$];
    list_res_t expected_results[$];

    // The predictor keeps the list as an ordered array of values; slot
    // allocation is invisible from the outside so it need not be modelled.
    logic [31:0] shadow_list[$];

    int cycle_count;
    int mismatches;
    int results_seen;
    int reqs_sent;
    bit stimulus_done;
    bit quiet_phase;

    // Set by the monitor when the current request was taken at the last edge.
    logic s_tready_seen;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int find_value(logic [31:0] v);
        for (int k = 0; k < shadow_list.size(); k++)
        begin
            if (shadow_list[k] == v)
                return k;
        end
        return -1;
    endfunction

    function automatic list_res_t make_result(logic [2:0] st, int p, logic [31:0] v);
        list_res_t r;
        r.status    = st;
        r.found_pos = p[6:0];
        r.elem      = v;
        r.last      = 1'b1;
        r.count     = 7'(shadow_list.size());
        return r;
    endfunction

    // Work out the results of one request and update the shadow list.
    task automatic predict_request(input list_req_t rq);
        int        n;
        int        idx;
        int        f;
        int        p;
        logic [2:0] st;
        list_res_t r;
        n   = shadow_list.size();
        p   = rq.pos;
        idx = -1;
        st  = ST_OK;
        if (rq.func > F_DUMP)
            return;
        if (rq.func == F_DUMP)
        begin
            if (n == 0)
                expected_results.push_back(make_result(ST_EMPTY, 0, '0));
            for (int k = 0; k < n; k++)
            begin
                r = make_result(ST_OK, k + 1, shadow_list[k]);
                r.last = (k == n - 1);
                expected_results.push_back(r);
            end
            return;
        end
        if (rq.func == F_SEARCH)
        begin
            f = find_value(rq.value);
            if (n == 0)
                expected_results.push_back(make_result(ST_EMPTY, 0, '0));
            else if (f < 0)
                expected_results.push_back(make_result(ST_NOKEY, 0, '0));
            else
                expected_results.push_back(make_result(ST_OK, f + 1, rq.value));
            return;
        end
        if (rq.func <= F_INS_LAST)
        begin
            if (n >= CAP)
                st = ST_FULL;
            else
            begin
                case (rq.func)
                    F_INS_FIRST:   idx = 0;
                    F_INS_BEF_POS: if (p >= 2 && p - 2 <= n) idx = p - 2; else st = ST_BADPOS;
                    F_INS_AT_POS:  if (p >= 1 && p - 1 <= n) idx = p - 1; else st = ST_BADPOS;
                    F_INS_AFT_POS: if (p >= 1 && p <= n) idx = p; else st = ST_BADPOS;
                    F_INS_BEF_KEY, F_INS_AFT_KEY:
                    begin
                        f = find_value(rq.key);
                        if (n == 0)
                            st = ST_EMPTY;
                        else if (f < 0)
                            st = ST_NOKEY;
                        else
                            idx = f + ((rq.func == F_INS_AFT_KEY) ? 1 : 0);
                    end
                    default:       idx = n;
                endcase
            end
            if (st == ST_OK)
                shadow_list.insert(idx, rq.value);
        end
        else
        begin
            if (n == 0)
                st = ST_EMPTY;
            else
            begin
                case (rq.func)
                    F_DEL_FIRST:   idx = 0;
                    F_DEL_BEF_POS: if (p >= 2 && p - 2 < n) idx = p - 2; else st = ST_BADPOS;
                    F_DEL_AT_POS:  if (p >= 1 && p - 1 < n) idx = p - 1; else st = ST_BADPOS;
                    F_DEL_AFT_POS: if (p >= 1 && p < n) idx = p; else st = ST_BADPOS;
                    F_DEL_BEF_KEY, F_DEL_AT_KEY, F_DEL_AFT_KEY:
                    begin
                        f = find_value(rq.key);
                        if (f < 0)
                            st = ST_NOKEY;
                        else
                        begin
                            idx = f + int'(rq.func) - int'(F_DEL_AT_KEY);
                            if (idx < 0 || idx >= n)
                                st = ST_BADPOS;
                        end
                    end
                    default:       idx = n - 1;
                endcase
            end
            if (st == ST_OK)
                shadow_list.delete(idx);
        end
        expected_results.push_back(make_result(st, 0, '0));
    endtask

    function automatic list_req_t build_req(logic [4:0] fn, logic [31:0] v, int p,
                                            logic [31:0] k);
        list_req_t rq;
        rq.func  = fn;
        rq.value = v;
        rq.pos   = p[15:0];
        rq.key   = k;
        return rq;
    endfunction

    // Values are drawn from a small pool most of the time so that keys and
    // searches hit; the rest are the two extreme words or fully random words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 7) - 3;
        endcase
    endfunction

    initial
    begin
        logic [4:0] fn;
        int         p;
        stimulus_done = 1'b0;
        // Directed part: empty-list answers, extremes of values and positions,
        // the head cases and key edges, and an undefined request code.
        pending_reqs.push_back(build_req(F_DUMP, 0, 0, 0));
        pending_reqs.push_back(build_req(F_SEARCH, 0, 0, 0));
        pending_reqs.push_back(build_req(F_DEL_FIRST, 0, 1, 0));
        pending_reqs.push_back(build_req(F_INS_BEF_KEY, 1, 0, 1));
        pending_reqs.push_back(build_req(F_INS_AT_POS, 32'h8000_0000, 0, 0));
        pending_reqs.push_back(build_req(F_INS_AT_POS, 32'h8000_0000, 1, 0));
        pending_reqs.push_back(build_req(F_DEL_AT_POS, 0, 1, 0));
        pending_reqs.push_back(build_req(F_INS_FIRST, 32'h7FFF_FFFF, 0, 0));
        pending_reqs.push_back(build_req(F_INS_LAST, 32'hFFFF_FFFF, 16'hFFFF, 0));
        pending_reqs.push_back(build_req(F_INS_BEF_POS, 5, 1, 0));
        pending_reqs.push_back(build_req(F_INS_BEF_POS, 5, 2, 0));
        pending_reqs.push_back(build_req(F_INS_AFT_POS, 6, 4, 0));
        pending_reqs.push_back(build_req(F_INS_AFT_POS, 7, 5, 0));
        pending_reqs.push_back(build_req(F_INS_AFT_KEY, 8, 0, 32'h7FFF_FFFF));
        pending_reqs.push_back(build_req(F_INS_BEF_KEY, 9, 0, 1234));
        pending_reqs.push_back(build_req(F_DEL_BEF_KEY, 0, 0, 5));
        pending_reqs.push_back(build_req(F_DEL_AFT_KEY, 0, 0, 6));
        pending_reqs.push_back(build_req(F_DEL_AFT_KEY, 0, 0, 5));
        pending_reqs.push_back(build_req(F_DEL_BEF_POS, 0, 3, 0));
        pending_reqs.push_back(build_req(F_DEL_AFT_POS, 0, 16'hFFFF, 0));
        pending_reqs.push_back(build_req(F_DEL_AT_KEY, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(build_req(5'd31, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(build_req(F_SEARCH, 9, 0, 0));
        pending_reqs.push_back(build_req(F_DUMP, 0, 0, 0));
        pending_reqs.push_back(build_req(F_DEL_LAST, 0, 0, 0));
        // Fill to capacity and beyond so that the full case is reached.
        for (int k = 0; k < CAP + 2; k++)
            pending_reqs.push_back(build_req(F_INS_LAST, pick_value(), 0, 0));
        pending_reqs.push_back(build_req(F_DUMP, 0, 0, 0));
        // Random part: mostly valid codes with positions kept near the list
        // length, plus a share of wild positions and undefined codes.
        for (int k = 0; k < RAND_REQS; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                fn = 5'($urandom_range(17, 31));
            else if ($urandom_range(0, 2) == 0)
                fn = 5'($urandom_range(0, 6));
            else
                fn = 5'($urandom_range(0, 16));
            if ($urandom_range(0, 9) == 0)
                p = $urandom_range(0, 65535);
            else
                p = $urandom_range(0, CAP + 2);
            pending_reqs.push_back(build_req(fn, pick_value(), p, pick_value()));
        end
        // Drain the list completely at the end, then dump the empty list.
        for (int k = 0; k < CAP + 1; k++)
            pending_reqs.push_back(build_req(F_DEL_FIRST, 0, 0, 0));
        pending_reqs.push_back(build_req(F_DUMP, 0, 0, 0));
        stimulus_done = 1'b1;
    end

    // Reset; the global cycle counter runs in the monitor below.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // The driver changes its outputs on the falling edge only; the request is
    // taken at the rising edge where tvalid and tready are both high, and the
    // prediction is made at that same edge in the monitor below.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= '0;
            m_tready    <= 1'b0;
            quiet_phase <= 1'b0;
        end
        else
        begin
            // A long stretch in the middle of the run has no idling at all.
            quiet_phase <= (reqs_sent > 80 && reqs_sent < 140);
            if (!s_tvalid || s_tready_seen)
            begin
                if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 24))
                begin
                    s_tvalid <= 1'b1;
                    {s_tuser, s_tdata} <= {pending_reqs[0].func, pending_reqs[0].key,
                                           pending_reqs[0].pos, pending_reqs[0].value};
                    void'(pending_reqs.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= quiet_phase || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        list_req_t rq;
        list_res_t got;
        list_res_t exp_r;
        if (!rst_n)
        begin
            s_tready_seen <= 1'b0;
            cycle_count   <= 0;
            mismatches    <= 0;
            results_seen  <= 0;
            reqs_sent     <= 0;
        end
        else
        begin
            cycle_count   <= cycle_count + 1;
            s_tready_seen <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                rq.func  = s_tuser;
                rq.value = s_tdata[31:0];
                rq.pos   = s_tdata[47:32];
                rq.key   = s_tdata[79:48];
                predict_request(rq);
                reqs_sent <= reqs_sent + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser;
                got.found_pos = m_tdata[6:0];
                got.elem      = m_tdata[38:7];
                got.last      = m_tlast;
                got.count     = m_tdata[45:39];
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected result %p at cycle %0d", got, cycle_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        if (mismatches < 10)
                            $display("Mismatch at cycle %0d: expected %p, got %p",
                                     cycle_count, exp_r, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    // End of run: all requests taken, nothing outstanding, then a drain pause
    // long enough for an ignored request or a trailing result to show up.
    initial
    begin
        wait (rst_n === 1'b1);
        while (!(stimulus_done && pending_reqs.size() == 0 && !s_tvalid
                 && expected_results.size() == 0) && cycle_count < LIMIT)
            @(posedge clk);
        repeat (2 * CAP + 20) @(posedge clk);
        if (cycle_count >= LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILURE");
        end
        else
        begin
            $display("Covered %0d list requests and %0d results, %0d mismatches.",
                     reqs_sent, results_seen, mismatches);
            if (mismatches == 0 && expected_results.size() == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/olst_pkg.sv
src/olst_ram.sv
src/olst_ctrl.sv
src/olst_dp.sv
src/ordered_list_engine_unit.sv
tb/testbench.sv
